@@ hw/rtl/fbbce_pkg.sv @@
package fbbce_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int TAG_W       = 16;
  localparam int SIZE_W      = 16;
  localparam int REMOVED_W   = 20;
  localparam int OCC_W       = 32;
  localparam int COUNT_W     = 5;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int WORD_W      = TAG_W + SIZE_W;

  localparam logic [ADDR_W-3:0] REG_MAX_STORE_BYTES = '0;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_CMP = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [OCC_W-1:0]   acc;
    logic [SIZE_W-1:0]  operand;
    logic [OCC_W-1:0]   limit;
  } alu_req_t;

  typedef struct packed {
    logic [OCC_W-1:0] value;
    logic             over;
  } alu_rsp_t;

endpackage

@@ hw/rtl/fbbce_mem.sv @@
module fbbce_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [fbbce_pkg::IDX_W-1:0]  wr_addr,
  input  logic [fbbce_pkg::WORD_W-1:0] wr_data,
  input  logic [fbbce_pkg::IDX_W-1:0]  rd_addr,
  output logic [fbbce_pkg::WORD_W-1:0] rd_data
);
  import fbbce_pkg::*;

  logic [WORD_W-1:0] mem [STORE_DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/fbbce_alu.sv @@
module fbbce_alu (
  input  fbbce_pkg::alu_req_t req,
  output fbbce_pkg::alu_rsp_t rsp
);
  import fbbce_pkg::*;

  logic [OCC_W:0] operand_x;
  logic [OCC_W:0] sum;
  logic           is_sub;

  always_comb begin
    is_sub    = (req.op == ALU_SUB);
    operand_x = is_sub ? ~{{(OCC_W + 1 - SIZE_W){1'b0}}, req.operand}
                       : {{(OCC_W + 1 - SIZE_W){1'b0}}, req.operand};
    sum       = {1'b0, req.acc} + operand_x + (OCC_W + 1)'(is_sub);
    rsp.value = sum[OCC_W-1:0];
    rsp.over  = 1'b0;
    case (req.op)
      ALU_ADD: begin
        rsp.value = sum[OCC_W] ? '1 : sum[OCC_W-1:0];
      end
      ALU_SUB: begin
        rsp.value = sum[OCC_W] ? '0 : sum[OCC_W-1:0];
      end
      ALU_CMP: begin
        rsp.over = (sum > {1'b0, req.limit});
      end
      default: begin
        rsp.value = sum[OCC_W-1:0];
      end
    endcase
  end

endmodule

@@ hw/rtl/fifo_byte_budget_cache_evict_core.sv @@
// FIFO cache store with a byte budget. Each input transfer inserts one entry
// (tag and size) at the back of a 16-entry FIFO. Before the insert, the oldest
// entries are evicted while the store is full by count, or while the budget
// is non-zero and the held bytes plus the new size exceed it; eviction stops
// when the store runs empty. Each eviction gives one result transfer, and a
// completion result with last set follows. The budget is register 0 at byte
// address 0 of the APB port and resets to zero, which disables byte-driven
// eviction. The sequencer steps through a check, an evict and a result state
// per eviction, then an insert and the completion result; it runs every
// occupancy compare, subtract and add through one shared 33-bit adder and
// reads the head entry from a registered memory port. Result stalls hold it.
// The input is stalled until the completion result has been transferred.
module fifo_byte_budget_cache_evict_core (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fbbce_pkg::ADDR_W-1:0]     paddr,
  input  logic [fbbce_pkg::DATA_W-1:0]     pwdata,
  output logic [fbbce_pkg::DATA_W-1:0]     prdata,
  output logic                             pready,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fbbce_pkg::TAG_W-1:0]      in_entry_tag,
  input  logic [fbbce_pkg::SIZE_W-1:0]     in_payload_bytes,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_result_kind,
  output logic [fbbce_pkg::TAG_W-1:0]      out_evicted_tag,
  output logic [fbbce_pkg::SIZE_W-1:0]     out_evicted_bytes,
  output logic [fbbce_pkg::REMOVED_W-1:0]  out_removed_total,
  output logic [fbbce_pkg::OCC_W-1:0]      out_occupancy_bytes,
  output logic [fbbce_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                             out_last
);
  import fbbce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_EVICT  = 5'b00100,
    S_INSERT = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [OCC_W-1:0]     max_bytes_r;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [OCC_W-1:0]     held_r, held_nxt;
  logic [REMOVED_W-1:0] removed_r, removed_nxt;
  logic [TAG_W-1:0]     tag_r;
  logic [SIZE_W-1:0]    size_r;

  logic                 kind_r, last_r;
  logic [TAG_W-1:0]     etag_r;
  logic [SIZE_W-1:0]    ebytes_r;
  logic [REMOVED_W-1:0] oremoved_r;
  logic [OCC_W-1:0]     occ_r;
  logic [COUNT_W-1:0]   ocount_r;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;
  logic [WORD_W-1:0]    head_word;
  logic [TAG_W-1:0]     head_tag;
  logic [SIZE_W-1:0]    head_size;
  logic [REMOVED_W:0]   removed_sum;
  logic                 store_full;
  logic                 do_evict;
  logic                 mem_wr_en;
  logic                 in_xfer;
  logic                 out_xfer;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (paddr[ADDR_W-1:2] == REG_MAX_STORE_BYTES) ? max_bytes_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= '0;
    end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_MAX_STORE_BYTES) begin
      max_bytes_r <= pwdata;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign out_xfer  = out_valid && !out_stall;

  assign head_tag  = head_word[WORD_W-1:SIZE_W];
  assign head_size = head_word[SIZE_W-1:0];
  assign mem_wr_en = (state_r == S_INSERT);

  fbbce_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (tail_r),
    .wr_data ({tag_r, size_r}),
    .rd_addr (head_r),
    .rd_data (head_word)
  );

  always_comb begin
    alu_req.acc   = held_r;
    alu_req.limit = max_bytes_r;
    case (state_r)
      S_EVICT: begin
        alu_req.op      = ALU_SUB;
        alu_req.operand = head_size;
      end
      S_INSERT: begin
        alu_req.op      = ALU_ADD;
        alu_req.operand = size_r;
      end
      default: begin
        alu_req.op      = ALU_CMP;
        alu_req.operand = size_r;
      end
    endcase
  end

  fbbce_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign store_full  = (count_r == CNT_W'(STORE_DEPTH));
  assign do_evict    = (count_r != '0) &&
                       (store_full || (max_bytes_r != '0 && alu_rsp.over));
  assign removed_sum = {1'b0, removed_r} + (REMOVED_W + 1)'(head_size);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    held_nxt    = held_r;
    removed_nxt = removed_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          removed_nxt = '0;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = do_evict ? S_EVICT : S_INSERT;
      end
      S_EVICT: begin
        head_nxt    = (head_r == IDX_W'(STORE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
        count_nxt   = count_r - CNT_W'(1);
        held_nxt    = alu_rsp.value;
        removed_nxt = removed_sum[REMOVED_W] ? '1 : removed_sum[REMOVED_W-1:0];
        state_nxt   = S_OUT;
      end
      S_INSERT: begin
        tail_nxt  = (tail_r == IDX_W'(STORE_DEPTH - 1)) ? '0 : tail_r + IDX_W'(1);
        count_nxt = count_r + CNT_W'(1);
        held_nxt  = alu_rsp.value;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_xfer) begin
          state_nxt = last_r ? S_IDLE : S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
    if (in_xfer) begin
      tag_r  <= in_entry_tag;
      size_r <= in_payload_bytes;
    end
    if (state_r == S_EVICT) begin
      kind_r     <= 1'b0;
      last_r     <= 1'b0;
      etag_r     <= head_tag;
      ebytes_r   <= head_size;
      oremoved_r <= removed_nxt;
      occ_r      <= held_nxt;
      ocount_r   <= COUNT_W'(count_nxt);
    end else if (state_r == S_INSERT) begin
      kind_r     <= 1'b1;
      last_r     <= 1'b1;
      etag_r     <= '0;
      ebytes_r   <= '0;
      oremoved_r <= removed_nxt;
      occ_r      <= held_nxt;
      ocount_r   <= COUNT_W'(count_nxt);
    end
  end

  assign out_result_kind     = kind_r;
  assign out_evicted_tag     = etag_r;
  assign out_evicted_bytes   = ebytes_r;
  assign out_removed_total   = oremoved_r;
  assign out_occupancy_bytes = occ_r;
  assign out_entry_count     = ocount_r;
  assign out_last            = last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STORE_DEPTH))
    else $error("Entry count exceeds the store depth.");

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_CHECK)
    else $error("Accepted insert did not start the eviction check.");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVICT |-> count_r != '0)
    else $error("Eviction started on an empty store.");

  a_kind_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind == out_last)
    else $error("Result kind and last flag disagree.");

  a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_entry_count != '0)
    else $error("Completion result reports an empty store.");

endmodule

@@ test/fifo_byte_budget_cache_evict_core_tb.sv @@
module fifo_byte_budget_cache_evict_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbbce_pkg::*;

  localparam int RANDOM_ITEMS    = 447;
  localparam int DIR_ROWS        = 15;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;

  localparam logic [ADDR_W-3:0] REG_UNMAPPED = 1'b1;

  typedef enum logic {
    KIND_EVICT = 1'b0,
    KIND_DONE  = 1'b1
  } report_kind_t;

  typedef enum logic {
    ROW_WRITE  = 1'b0,
    ROW_INSERT = 1'b1
  } row_kind_t;

  typedef struct packed {
    report_kind_t           kind;
    logic [TAG_W-1:0]       tag;
    logic [SIZE_W-1:0]      bytes;
    logic [REMOVED_W-1:0]   removed;
    logic [OCC_W-1:0]       occ;
    logic [COUNT_W-1:0]     count;
    logic                   last;
  } report_t;

  typedef struct packed {
    logic [TAG_W-1:0]       tag;
    logic [SIZE_W-1:0]      size;
    logic                   pinned;
    logic [REMOVED_W-1:0]   pin_removed;
    logic [OCC_W-1:0]       pin_occ;
    logic [COUNT_W-1:0]     pin_count;
  } insert_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [ADDR_W-3:0]      reg_idx;
    logic [DATA_W-1:0]      value;
    logic [TAG_W-1:0]       tag;
    logic [SIZE_W-1:0]      size;
    logic [7:0]             reps;
    logic                   pinned;
    logic [REMOVED_W-1:0]   pin_removed;
    logic [OCC_W-1:0]       pin_occ;
    logic [COUNT_W-1:0]     pin_count;
  } row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]      pwdata;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_stall;
  logic [TAG_W-1:0]       in_entry_tag;
  logic [SIZE_W-1:0]      in_payload_bytes;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_result_kind;
  logic [TAG_W-1:0]       out_evicted_tag;
  logic [SIZE_W-1:0]      out_evicted_bytes;
  logic [REMOVED_W-1:0]   out_removed_total;
  logic [OCC_W-1:0]       out_occupancy_bytes;
  logic [COUNT_W-1:0]     out_entry_count;
  logic                   out_last;

  fifo_byte_budget_cache_evict_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_entry_tag        (in_entry_tag),
    .in_payload_bytes    (in_payload_bytes),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_evicted_tag     (out_evicted_tag),
    .out_evicted_bytes   (out_evicted_bytes),
    .out_removed_total   (out_removed_total),
    .out_occupancy_bytes (out_occupancy_bytes),
    .out_entry_count     (out_entry_count),
    .out_last            (out_last)
  );

  // The pinned rows carry completion values that follow directly from the
  // fill pattern: a full store, a budget of one byte, and a store run empty.
  row_t directed_rows [DIR_ROWS] = '{
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'hFFFF, 16'hFFFF, 8'd1,
      1'b1, 20'd0, 32'd65535, 5'd1},
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'h0000, 16'h0000, 8'd1,
      1'b1, 20'd0, 32'd65535, 5'd2},
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'h0002, 16'h1000, 8'd14,
      1'b0, 20'd0, 32'd0, 5'd0},
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'h0011, 16'h0000, 8'd1,
      1'b1, 20'd65535, 32'd57344, 5'd16},
    '{ROW_WRITE, REG_MAX_STORE_BYTES, 32'd1, 16'h0000, 16'h0000, 8'd0,
      1'b0, 20'd0, 32'd0, 5'd0},
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'hA5A5, 16'h0002, 8'd1,
      1'b1, 20'd57344, 32'd2, 5'd1},
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'h5A5A, 16'h0000, 8'd1,
      1'b1, 20'd2, 32'd0, 5'd1},
    '{ROW_WRITE, REG_MAX_STORE_BYTES, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 8'd0,
      1'b0, 20'd0, 32'd0, 5'd0},
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'h8000, 16'hFFFF, 8'd1,
      1'b0, 20'd0, 32'd0, 5'd0},
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'h7FFF, 16'h8000, 8'd1,
      1'b0, 20'd0, 32'd0, 5'd0},
    '{ROW_WRITE, REG_UNMAPPED, 32'd16, 16'h0000, 16'h0000, 8'd0,
      1'b0, 20'd0, 32'd0, 5'd0},
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'h0001, 16'hFFFF, 8'd1,
      1'b0, 20'd0, 32'd0, 5'd0},
    '{ROW_WRITE, REG_MAX_STORE_BYTES, 32'h0002_0000, 16'h0000, 16'h0000, 8'd0,
      1'b0, 20'd0, 32'd0, 5'd0},
    '{ROW_INSERT, REG_MAX_STORE_BYTES, 32'd0, 16'h0F0F, 16'hF0F0, 8'd1,
      1'b0, 20'd0, 32'd0, 5'd0},
    '{ROW_WRITE, REG_MAX_STORE_BYTES, 32'd0, 16'h0000, 16'h0000, 8'd0,
      1'b0, 20'd0, 32'd0, 5'd0}
  };

  logic [TAG_W-1:0]   shadow_tag  [STORE_DEPTH];
  logic [SIZE_W-1:0]  shadow_size [STORE_DEPTH];
  logic [IDX_W-1:0]   shadow_head;
  logic [IDX_W-1:0]   shadow_tail;
  logic [COUNT_W-1:0] shadow_count;
  logic [OCC_W-1:0]   shadow_bytes;
  logic [DATA_W-1:0]  shadow_budget;

  insert_t insert_q [$];
  report_t report_q [$];

  int  inserts_queued;
  int  inserts_taken;
  int  directed_inserts;
  int  evict_seen;
  int  done_seen;
  int  budget_writes;
  int  longest_burst;
  int  holds_done;
  int  mismatches;
  bit  tx_calm;
  bit  rx_calm;
  bit  hold_off_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(STORE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_payload();
    logic [31:0] rnd;
    case ($urandom_range(0, 5))
      0: rnd = $urandom_range(0, 255);
      1: rnd = ($urandom_range(0, 1) != 0) ? 32'h0000_FFFF : 32'h0;
      2: rnd = $urandom_range(4096, 32768);
      default: rnd = $urandom;
    endcase
    return rnd[SIZE_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  task automatic apply_insert(input insert_t it);
    report_t          r;
    logic [OCC_W:0]   need;
    logic [OCC_W:0]   total;
    logic [REMOVED_W:0] rsum;
    logic [REMOVED_W-1:0] removed;
    logic [SIZE_W-1:0] esize;
    bit               evicting;
    int               burst;
    removed  = '0;
    burst    = 0;
    evicting = 1'b1;
    while (evicting) begin
      need = {1'b0, shadow_bytes} + (OCC_W + 1)'(it.size);
      if (shadow_count == '0) begin
        evicting = 1'b0;
      end else if (shadow_count < COUNT_W'(STORE_DEPTH) &&
                   (shadow_budget == '0 || need <= {1'b0, shadow_budget})) begin
        evicting = 1'b0;
      end else begin
        esize        = shadow_size[shadow_head];
        r.kind       = KIND_EVICT;
        r.tag        = shadow_tag[shadow_head];
        r.bytes      = esize;
        shadow_head  = next_slot(shadow_head);
        shadow_count = shadow_count - COUNT_W'(1);
        if (OCC_W'(esize) > shadow_bytes) begin
          shadow_bytes = '0;
        end else begin
          shadow_bytes = shadow_bytes - OCC_W'(esize);
        end
        rsum    = {1'b0, removed} + (REMOVED_W + 1)'(esize);
        removed = rsum[REMOVED_W] ? '1 : rsum[REMOVED_W-1:0];
        r.removed = removed;
        r.occ     = shadow_bytes;
        r.count   = shadow_count;
        r.last    = 1'b0;
        report_q.insert(report_q.size(), r);
        burst++;
      end
    end
    shadow_tag[shadow_tail]  = it.tag;
    shadow_size[shadow_tail] = it.size;
    shadow_tail  = next_slot(shadow_tail);
    shadow_count = shadow_count + COUNT_W'(1);
    total        = {1'b0, shadow_bytes} + (OCC_W + 1)'(it.size);
    shadow_bytes = total[OCC_W] ? '1 : total[OCC_W-1:0];
    r.kind  = KIND_DONE;
    r.tag   = '0;
    r.bytes = '0;
    r.last  = 1'b1;
    if (it.pinned) begin
      r.removed = it.pin_removed;
      r.occ     = it.pin_occ;
      r.count   = it.pin_count;
    end else begin
      r.removed = removed;
      r.occ     = shadow_bytes;
      r.count   = shadow_count;
    end
    report_q.insert(report_q.size(), r);
    if (burst + 1 > longest_burst) longest_burst = burst + 1;
  endtask

  task automatic check_report(input report_t got);
    report_t want;
    if (report_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Report with nothing outstanding: kind %0d tag 0x%0h last %0d",
                 got.kind, got.tag, got.last);
      end
    end else begin
      want = report_q[0];
      report_q.delete(0);
      if (got.kind != want.kind) flag_mismatch("result_kind", want.kind, got.kind);
      if (got.tag != want.tag) flag_mismatch("evicted_tag", want.tag, got.tag);
      if (got.bytes != want.bytes) flag_mismatch("evicted_bytes", want.bytes, got.bytes);
      if (got.removed != want.removed) begin
        flag_mismatch("removed_total", want.removed, got.removed);
      end
      if (got.occ != want.occ) flag_mismatch("occupancy_bytes", want.occ, got.occ);
      if (got.count != want.count) flag_mismatch("entry_count", want.count, got.count);
      if (got.last != want.last) flag_mismatch("last", want.last, got.last);
    end
  endtask

  task automatic settle_store();
    while (inserts_taken != inserts_queued || report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_insert(input insert_t it);
    insert_q.insert(insert_q.size(), it);
    inserts_queued++;
  endtask

  task automatic set_register(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] value);
    settle_store();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_MAX_STORE_BYTES) begin
      shadow_budget = value;
      budget_writes++;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_MAX_STORE_BYTES, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != shadow_budget) flag_mismatch("max_store_bytes readback", shadow_budget, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : feed_inserts
    insert_t cur;
    int      gap_left;
    bit      fired;
    in_valid         <= 1'b0;
    in_entry_tag     <= '0;
    in_payload_bytes <= '0;
    gap_left = 0;
    cur      = '0;
    forever begin
      @(posedge clk);
      fired = rst_n && in_valid && !in_stall;
      if (fired) begin
        apply_insert(cur);
        inserts_taken++;
        gap_left = tx_calm ? 0 : pick_gap();
      end
      if (in_valid && !fired) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (insert_q.size() != 0) begin
        cur = insert_q[0];
        insert_q.delete(0);
        in_valid         <= 1'b1;
        in_entry_tag     <= cur.tag;
        in_payload_bytes <= cur.size;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  initial begin : take_reports
    report_t got;
    int      stall_left;
    int      hold_left;
    out_stall <= 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.kind    = report_kind_t'(out_result_kind);
        got.tag     = out_evicted_tag;
        got.bytes   = out_evicted_bytes;
        got.removed = out_removed_total;
        got.occ     = out_occupancy_bytes;
        got.count   = out_entry_count;
        got.last    = out_last;
        if (got.kind == KIND_DONE) done_seen++;
        else evict_seen++;
        check_report(got);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = rx_calm ? 0 : pick_gap();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : run_sequence
    insert_t           it;
    logic [31:0]       rnd;
    logic [DATA_W-1:0] budget;
    int                idx;
    int                k;
    int                rand_left;
    int                phase_len;
    bit                first_phase;
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    shadow_head   = '0;
    shadow_tail   = '0;
    shadow_count  = '0;
    shadow_bytes  = '0;
    shadow_budget = '0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    hold_off_req  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (idx = 0; idx < DIR_ROWS; idx++) begin
      if (directed_rows[idx].kind == ROW_WRITE) begin
        set_register(directed_rows[idx].reg_idx, directed_rows[idx].value);
      end else begin
        for (k = 0; k < int'(directed_rows[idx].reps); k++) begin
          it.tag         = directed_rows[idx].tag + TAG_W'(k);
          it.size        = directed_rows[idx].size;
          it.pinned      = directed_rows[idx].pinned;
          it.pin_removed = directed_rows[idx].pin_removed;
          it.pin_occ     = directed_rows[idx].pin_occ;
          it.pin_count   = directed_rows[idx].pin_count;
          queue_insert(it);
          directed_inserts++;
        end
      end
    end

    rand_left   = RANDOM_ITEMS;
    first_phase = 1'b1;
    while (rand_left > 0) begin
      case ($urandom_range(0, 4))
        0: budget = '0;
        1: budget = $urandom_range(1, 255);
        2: budget = $urandom_range(65536, 400000);
        3: budget = $urandom;
        default: budget = '1;
      endcase
      set_register(REG_MAX_STORE_BYTES, budget);
      if ($urandom_range(0, 3) == 0) set_register(REG_UNMAPPED, $urandom);
      tx_calm   = ($urandom_range(0, 3) == 0);
      rx_calm   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(25, 60);
      if (phase_len > rand_left) phase_len = rand_left;
      for (k = 0; k < phase_len; k++) begin
        rnd            = $urandom;
        it.tag         = rnd[TAG_W-1:0];
        it.size        = pick_payload();
        it.pinned      = 1'b0;
        it.pin_removed = '0;
        it.pin_occ     = '0;
        it.pin_count   = '0;
        queue_insert(it);
      end
      rand_left -= phase_len;
      if (first_phase) begin
        hold_off_req = 1'b1;
        first_phase  = 1'b0;
      end
    end

    settle_store();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (report_q.size() != 0) begin
      $display("%0d predicted reports never arrived", report_q.size());
      mismatches += report_q.size();
    end
    $display("Run covered %0d inserts (%0d directed) under %0d budget settings.",
             inserts_taken, directed_inserts, budget_writes);
    $display("Saw %0d eviction reports and %0d completions; longest insert gave %0d reports.",
             evict_seen, done_seen, longest_burst);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/fbbce_pkg.sv
hw/rtl/fbbce_mem.sv
hw/rtl/fbbce_alu.sv
hw/rtl/fifo_byte_budget_cache_evict_core.sv
test/fifo_byte_budget_cache_evict_core_tb.sv
